@@ src/hdt_pkg.sv @@
// hdt_pkg: widths, register indexes, reset values and shared types of the
// helmert datum transform; used by the top level and by its checker
// depends on nothing
`default_nettype none

package hdt_pkg;

    // field and register widths
    localparam int COORD_W = 34;             // coordinate, mm
    localparam int REG_W   = 32;             // every configuration register
    localparam int FRAC_W  = 40;             // fraction bits of angles and scale
    localparam int IDX_W   = 3;              // register index

    // derived datapath widths
    localparam int ROT_W   = REG_W + COORD_W;        // angle * coordinate
    localparam int ACC_W   = ROT_W + 1;              // difference of two products
    localparam int RND_W   = ACC_W - FRAC_W;         // rounded rotation term
    localparam int T_W     = COORD_W + 1;            // rotated coordinate
    localparam int SPR_W   = REG_W + T_W;            // scale * rotated coordinate
    localparam int SRND_W  = SPR_W - FRAC_W;         // rounded scale term
    localparam int SUM_W   = T_W + 2;                // shift + t + scale term

    // register indexes
    localparam logic [IDX_W-1:0] IDX_SHIFT_X   = 3'd0;
    localparam logic [IDX_W-1:0] IDX_SHIFT_Y   = 3'd1;
    localparam logic [IDX_W-1:0] IDX_SHIFT_Z   = 3'd2;
    localparam logic [IDX_W-1:0] IDX_ANGLE_X   = 3'd3;
    localparam logic [IDX_W-1:0] IDX_ANGLE_Y   = 3'd4;
    localparam logic [IDX_W-1:0] IDX_ANGLE_Z   = 3'd5;
    localparam logic [IDX_W-1:0] IDX_SCALE_DEV = 3'd6;

    // register values after reset
    localparam logic signed [REG_W-1:0] RST_SHIFT_X   = 32'sd127622;
    localparam logic signed [REG_W-1:0] RST_SHIFT_Y   = 32'sd67245;
    localparam logic signed [REG_W-1:0] RST_SHIFT_Z   = 32'sd47043;
    localparam logic signed [REG_W-1:0] RST_ANGLE_X   = -32'sd16352202;
    localparam logic signed [REG_W-1:0] RST_ANGLE_Y   = 32'sd26135367;
    localparam logic signed [REG_W-1:0] RST_ANGLE_Z   = 32'sd8411126;
    localparam logic signed [REG_W-1:0] RST_SCALE_DEV = 32'sd1165504;

    // direction codes
    localparam logic FUNC_FORWARD = 1'b0;
    localparam logic FUNC_REVERSE = 1'b1;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [REG_W-1:0]   cfg_reg_t;

    // coordinate range bounds
    localparam coord_t COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam coord_t COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

endpackage

`default_nettype wire

@@ src/helmert_datum_transform.sv @@
// helmert_datum_transform: five-stage pipelined seven-parameter helmert
// transform of one earth-centred xyz point per transfer
// depends on hdt_pkg
`default_nettype none

// usage
//  - input channel in_valid / in_ready carries func, pos_x, pos_y, pos_z;
//    a transfer takes place at a rising edge with both high
//  - output channel out_valid / out_ready carries out_x, out_y, out_z and
//    clipped, one result for every input transfer, in order
//  - configuration: cfg_we, cfg_addr, cfg_wdata write one register per
//    edge (0..2 shifts, 3..5 angles, 6 scale deviation); index 7 ignored;
//    write only while no point is in flight
//  - pipeline: stage 1 rotation multipliers, stage 2 row sums, stage 3
//    rounding, stage 4 scale multipliers, stage 5 sum and saturation; a
//    point is shown on the output once it sits in the stage 5 register
//  - throughput: one point per cycle while out_ready allows, set by the six
//    32x34 rotation and three 32x35 scale multipliers, each owning a stage
//  - stall: every stage has its own valid bit and takes a new point when
//    it is empty or its successor moves, so bubbles close up and input is
//    still taken while a result waits on out_ready if any stage is empty
//  - reset: all valid bits clear and the configuration registers return
//    to their default parameter set; no clearing pass is needed
module helmert_datum_transform
(
    input  wire                          clk,
    input  wire                          rst_n,
    // configuration write port
    input  wire                          cfg_we,
    input  wire  [hdt_pkg::IDX_W-1:0]    cfg_addr,
    input  wire  [hdt_pkg::REG_W-1:0]    cfg_wdata,
    // input channel
    input  wire                          in_valid,
    output logic                         in_ready,
    input  wire                          func,
    input  wire  [hdt_pkg::COORD_W-1:0]  pos_x,
    input  wire  [hdt_pkg::COORD_W-1:0]  pos_y,
    input  wire  [hdt_pkg::COORD_W-1:0]  pos_z,
    // output channel
    output logic                         out_valid,
    input  wire                          out_ready,
    output logic [hdt_pkg::COORD_W-1:0]  out_x,
    output logic [hdt_pkg::COORD_W-1:0]  out_y,
    output logic [hdt_pkg::COORD_W-1:0]  out_z,
    output logic                         clipped
);

    localparam int NSTG = 5;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    hdt_pkg::cfg_reg_t shift_reg [3];
    hdt_pkg::cfg_reg_t angle_x_reg, angle_y_reg, angle_z_reg, scale_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg[0] <= hdt_pkg::RST_SHIFT_X;
            shift_reg[1] <= hdt_pkg::RST_SHIFT_Y;
            shift_reg[2] <= hdt_pkg::RST_SHIFT_Z;
            angle_x_reg  <= hdt_pkg::RST_ANGLE_X;
            angle_y_reg  <= hdt_pkg::RST_ANGLE_Y;
            angle_z_reg  <= hdt_pkg::RST_ANGLE_Z;
            scale_reg    <= hdt_pkg::RST_SCALE_DEV;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                hdt_pkg::IDX_SHIFT_X:   shift_reg[0] <= cfg_wdata;
                hdt_pkg::IDX_SHIFT_Y:   shift_reg[1] <= cfg_wdata;
                hdt_pkg::IDX_SHIFT_Z:   shift_reg[2] <= cfg_wdata;
                hdt_pkg::IDX_ANGLE_X:   angle_x_reg  <= cfg_wdata;
                hdt_pkg::IDX_ANGLE_Y:   angle_y_reg  <= cfg_wdata;
                hdt_pkg::IDX_ANGLE_Z:   angle_z_reg  <= cfg_wdata;
                hdt_pkg::IDX_SCALE_DEV: scale_reg    <= cfg_wdata;
                default:                ;   // index beyond the list: ignored
            endcase
        end
    end

    // ------------------------------------------------------------------
    // pipeline flow control: a stage loads when empty or when drained
    // ------------------------------------------------------------------
    logic [NSTG-1:0] valid_reg, valid_next;
    logic [NSTG-1:0] load;

    always_comb
    begin
        load[NSTG-1] = !valid_reg[NSTG-1] || out_ready;
        for (int k = NSTG - 2; k >= 0; k--)
        begin
            load[k] = !valid_reg[k] || load[k+1];
        end
        valid_next[0] = load[0] ? in_valid : valid_reg[0];
        for (int k = 1; k < NSTG; k++)
        begin
            valid_next[k] = load[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_ready  = load[0];
    assign out_valid = valid_reg[NSTG-1];

    // ------------------------------------------------------------------
    // stage 1: rotation products
    // row i sum is prod_a - prod_b, row order x, y, z:
    //   x: az*py - ay*pz   y: ax*pz - az*px   z: ay*px - ax*py
    // ------------------------------------------------------------------
    logic signed [hdt_pkg::ROT_W-1:0] prod_a_reg [3], prod_a_next [3];
    logic signed [hdt_pkg::ROT_W-1:0] prod_b_reg [3], prod_b_next [3];
    hdt_pkg::coord_t                  pos1_reg [3];
    logic                             rev1_reg;

    hdt_pkg::coord_t px, py, pz;

    always_comb
    begin
        px = pos_x;
        py = pos_y;
        pz = pos_z;
        prod_a_next[0] = hdt_pkg::ROT_W'(angle_z_reg) * hdt_pkg::ROT_W'(py);
        prod_b_next[0] = hdt_pkg::ROT_W'(angle_y_reg) * hdt_pkg::ROT_W'(pz);
        prod_a_next[1] = hdt_pkg::ROT_W'(angle_x_reg) * hdt_pkg::ROT_W'(pz);
        prod_b_next[1] = hdt_pkg::ROT_W'(angle_z_reg) * hdt_pkg::ROT_W'(px);
        prod_a_next[2] = hdt_pkg::ROT_W'(angle_y_reg) * hdt_pkg::ROT_W'(px);
        prod_b_next[2] = hdt_pkg::ROT_W'(angle_x_reg) * hdt_pkg::ROT_W'(py);
    end

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            prod_a_reg  <= prod_a_next;
            prod_b_reg  <= prod_b_next;
            pos1_reg[0] <= px;
            pos1_reg[1] <= py;
            pos1_reg[2] <= pz;
            rev1_reg    <= (func == hdt_pkg::FUNC_REVERSE);
        end
    end

    // ------------------------------------------------------------------
    // stage 2: row sums; reverse negates every angle, hence the whole sum
    // ------------------------------------------------------------------
    logic signed [hdt_pkg::ACC_W-1:0] acc_reg [3], acc_next [3];
    logic signed [hdt_pkg::ACC_W-1:0] diff [3];
    hdt_pkg::coord_t                  pos2_reg [3];
    logic                             rev2_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            diff[i]     = hdt_pkg::ACC_W'(prod_a_reg[i]) - hdt_pkg::ACC_W'(prod_b_reg[i]);
            acc_next[i] = rev1_reg ? -diff[i] : diff[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[1])
        begin
            acc_reg  <= acc_next;
            pos2_reg <= pos1_reg;
            rev2_reg <= rev1_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 3: round to nearest (ties up) and add to the coordinate
    // ------------------------------------------------------------------
    localparam logic signed [hdt_pkg::ACC_W-1:0] ACC_HALF =
        hdt_pkg::ACC_W'(1) <<< (hdt_pkg::FRAC_W - 1);

    logic signed [hdt_pkg::T_W-1:0]   t3_reg [3], t3_next [3];
    logic signed [hdt_pkg::ACC_W-1:0] acc_rnd [3];
    logic signed [hdt_pkg::RND_W-1:0] rot_term [3];
    logic                             rev3_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            acc_rnd[i]  = acc_reg[i] + ACC_HALF;
            rot_term[i] = acc_rnd[i][hdt_pkg::ACC_W-1:hdt_pkg::FRAC_W];
            t3_next[i]  = hdt_pkg::T_W'(pos2_reg[i]) + hdt_pkg::T_W'(rot_term[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[2])
        begin
            t3_reg   <= t3_next;
            rev3_reg <= rev2_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 4: scale products
    // ------------------------------------------------------------------
    logic signed [hdt_pkg::SPR_W-1:0] sprod_reg [3], sprod_next [3];
    logic signed [hdt_pkg::T_W-1:0]   t4_reg [3];
    logic                             rev4_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sprod_next[i] = hdt_pkg::SPR_W'(scale_reg) * hdt_pkg::SPR_W'(t3_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[3])
        begin
            sprod_reg <= sprod_next;
            t4_reg    <= t3_reg;
            rev4_reg  <= rev3_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 5: shift + t + rounded scale term, saturate, output register
    // ------------------------------------------------------------------
    localparam logic signed [hdt_pkg::SPR_W-1:0] SPR_HALF =
        hdt_pkg::SPR_W'(1) <<< (hdt_pkg::FRAC_W - 1);
    localparam logic signed [hdt_pkg::SUM_W-1:0] SUM_MAX =
        hdt_pkg::SUM_W'(hdt_pkg::COORD_MAX);
    localparam logic signed [hdt_pkg::SUM_W-1:0] SUM_MIN =
        hdt_pkg::SUM_W'(hdt_pkg::COORD_MIN);

    logic signed [hdt_pkg::SPR_W-1:0]  sprod_rnd [3];
    logic signed [hdt_pkg::SRND_W-1:0] scale_term [3];
    logic signed [hdt_pkg::REG_W:0]    shift_dir [3];
    logic signed [hdt_pkg::SUM_W-1:0]  sum [3];
    hdt_pkg::coord_t                   res_next [3];
    hdt_pkg::coord_t                   res_reg [3];
    logic [2:0]                        sat;
    logic                              clip_next, clip_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sprod_rnd[i]  = sprod_reg[i] + SPR_HALF;
            scale_term[i] = sprod_rnd[i][hdt_pkg::SPR_W-1:hdt_pkg::FRAC_W];
            // reverse negates the translation, scale stays as it is
            shift_dir[i]  = rev4_reg ? -(hdt_pkg::REG_W+1)'(shift_reg[i])
                                     :  (hdt_pkg::REG_W+1)'(shift_reg[i]);
            sum[i] = hdt_pkg::SUM_W'(shift_dir[i]) + hdt_pkg::SUM_W'(t4_reg[i])
                   + hdt_pkg::SUM_W'(scale_term[i]);
            if (sum[i] > SUM_MAX)
            begin
                res_next[i] = hdt_pkg::COORD_MAX;
                sat[i]      = 1'b1;
            end
            else if (sum[i] < SUM_MIN)
            begin
                res_next[i] = hdt_pkg::COORD_MIN;
                sat[i]      = 1'b1;
            end
            else
            begin
                res_next[i] = sum[i][hdt_pkg::COORD_W-1:0];
                sat[i]      = 1'b0;
            end
        end
        clip_next = |sat;
    end

    always_ff @(posedge clk)
    begin
        if (load[4])
        begin
            res_reg  <= res_next;
            clip_reg <= clip_next;
        end
    end

    assign out_x   = res_reg[0];
    assign out_y   = res_reg[1];
    assign out_z   = res_reg[2];
    assign clipped = clip_reg;

endmodule

`default_nettype wire

@@ src/hdt_checker.sv @@
// hdt_checker: port-level assertions for helmert_datum_transform, bound
// to the top level; depends on hdt_pkg
`default_nettype none

module hdt_checker
(
    input wire                          clk,
    input wire                          rst_n,
    input wire                          in_ready,
    input wire                          out_valid,
    input wire                          out_ready,
    input wire [hdt_pkg::COORD_W-1:0]   out_x,
    input wire [hdt_pkg::COORD_W-1:0]   out_y,
    input wire [hdt_pkg::COORD_W-1:0]   out_z,
    input wire                          clipped
);

    // a pending result is held until its transfer
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_x) && $stable(out_y)
                                    && $stable(out_z) && $stable(clipped))
        else $error("result changed while stalled");

    // a clipped result has at least one axis at a bound
    a_clip_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && clipped |->
            out_x == hdt_pkg::COORD_MAX || out_x == hdt_pkg::COORD_MIN ||
            out_y == hdt_pkg::COORD_MAX || out_y == hdt_pkg::COORD_MIN ||
            out_z == hdt_pkg::COORD_MAX || out_z == hdt_pkg::COORD_MIN)
        else $error("clipped set with no axis at a bound");

    // a draining output lets the whole pipe move
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("input stalled while output drains");

endmodule

bind helmert_datum_transform hdt_checker u_hdt_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_x     (out_x),
    .out_y     (out_y),
    .out_z     (out_z),
    .clipped   (clipped)
);

`default_nettype wire
